[rtl/dgsp_pkg.sv]
package dgsp_pkg;

  // Default sizes of the block.
  localparam int unsigned DEF_MAX_VERTICES = 64;
  localparam int unsigned DEF_WEIGHT_BITS  = 16;

  // Fixed field widths of the ports.
  localparam int unsigned CFG_BITS  = 7;
  localparam int unsigned VID_BITS  = 6;
  localparam int unsigned WIN_BITS  = 16;
  localparam int unsigned DIST_BITS = 22;

  // Reset value of the vertex count register.
  localparam logic [CFG_BITS-1:0] CFG_RESET = 7'd64;

  // Saturation limit of path sums.
  localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

  // Request codes.
  localparam logic REQ_EDGE = 1'b0;
  localparam logic REQ_RUN  = 1'b1;

  // One word of the vertex store.
  typedef struct packed {
    logic                 visited;
    logic                 reached;
    logic [DIST_BITS-1:0] dist_val;
  } vtx_entry_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_SCAN_END,
    ST_RELAX,
    ST_RELAX_END,
    ST_EMIT
  } ctrl_state_e;

endpackage

[rtl/dgsp_edge_mem.sv]
module dgsp_edge_mem #(
  parameter int unsigned ADDR_BITS   = 12,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   we_i,
  input  logic [ADDR_BITS-1:0]   waddr_i,
  input  logic [WEIGHT_BITS-1:0] wdata_i,
  input  logic                   re_i,
  input  logic [ADDR_BITS-1:0]   raddr_i,
  output logic [WEIGHT_BITS-1:0] rdata_o,
  output logic                   clear_busy_o
);

  logic [WEIGHT_BITS-1:0] mem [2**ADDR_BITS];
  logic [ADDR_BITS-1:0]   clr_q;
  logic                   busy_q;

  // Clearing pass after reset, one entry per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      clr_q <= clr_q + ADDR_BITS'(1);
      if (clr_q == '1) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Weight array with one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_q] <= '0;
    end else if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

  assign clear_busy_o = busy_q;

endmodule

[rtl/dgsp_vtx_mem.sv]
module dgsp_vtx_mem #(
  parameter int unsigned ADDR_BITS = 6
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [ADDR_BITS-1:0]   waddr_i,
  input  dgsp_pkg::vtx_entry_t   wdata_i,
  input  logic                   re_i,
  input  logic [ADDR_BITS-1:0]   raddr_i,
  output dgsp_pkg::vtx_entry_t   rdata_o
);

  dgsp_pkg::vtx_entry_t mem [2**ADDR_BITS];

  // Per-vertex distance and marks, registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

[rtl/dgsp_ctrl.sv]
module dgsp_ctrl #(
  parameter int unsigned MAX_VERTICES = dgsp_pkg::DEF_MAX_VERTICES,
  parameter int unsigned WEIGHT_BITS  = dgsp_pkg::DEF_WEIGHT_BITS,
  parameter int unsigned VW           = $clog2(MAX_VERTICES),
  parameter int unsigned NW           = $clog2(MAX_VERTICES + 1)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [NW-1:0]                    n_i,
  input  logic                             clear_busy_i,
  // Request channel.
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             req_type_i,
  input  logic [dgsp_pkg::VID_BITS-1:0]    from_vertex_i,
  input  logic [dgsp_pkg::VID_BITS-1:0]    to_vertex_i,
  input  logic [dgsp_pkg::WIN_BITS-1:0]    weight_i,
  // Result channel.
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [dgsp_pkg::VID_BITS-1:0]    vertex_o,
  output logic [dgsp_pkg::DIST_BITS-1:0]   distance_o,
  output logic                             reachable_o,
  output logic                             last_o,
  // Weight memory port.
  output logic                             e_we_o,
  output logic [2*VW-1:0]                  e_waddr_o,
  output logic [WEIGHT_BITS-1:0]           e_wdata_o,
  output logic                             e_re_o,
  output logic [2*VW-1:0]                  e_raddr_o,
  input  logic [WEIGHT_BITS-1:0]           e_rdata_i,
  // Vertex memory port.
  output logic                             v_we_o,
  output logic [VW-1:0]                    v_waddr_o,
  output dgsp_pkg::vtx_entry_t             v_wdata_o,
  output logic                             v_re_o,
  output logic [VW-1:0]                    v_raddr_o,
  input  dgsp_pkg::vtx_entry_t             v_rdata_i
);

  localparam int unsigned CW = dgsp_pkg::VID_BITS + 1;
  localparam int unsigned SW =
    ((WEIGHT_BITS > dgsp_pkg::DIST_BITS) ? WEIGHT_BITS : dgsp_pkg::DIST_BITS) + 1;

  dgsp_pkg::ctrl_state_e state_q, state_d;
  logic [VW-1:0] cnt_q, cnt_d;
  logic [VW-1:0] round_q, round_d;
  logic [VW-1:0] n_m1;
  logic          in_accept, out_accept;
  logic          scan_iss, relax_iss, emit_iss, init_we;
  logic          scan_v_q, relax_v_q, emit_v_q;
  logic [VW-1:0] pipe_idx_q;
  logic          have_q, take;
  logic [VW-1:0] best_q;
  logic          best_reached_q;
  logic [dgsp_pkg::DIST_BITS-1:0] best_dist_q;
  logic          wb_we;
  dgsp_pkg::vtx_entry_t wb_entry;
  logic [SW-1:0] cand_full;
  logic [dgsp_pkg::DIST_BITS-1:0] cand;
  logic          from_ok, to_ok;
  logic [VW-1:0] fa, tb, e_hi, e_lo, r_hi, r_lo;
  logic          out_valid_q;
  logic [dgsp_pkg::VID_BITS-1:0]  out_vertex_q;
  logic [dgsp_pkg::DIST_BITS-1:0] out_dist_q;
  logic          out_reach_q, out_last_q;

  assign n_m1       = VW'(n_i - NW'(1));
  assign in_stall_o = (state_q != dgsp_pkg::ST_IDLE) || clear_busy_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_accept = out_valid_q && !out_stall_i;

  // Edge writes go to the lower triangle only, so one write covers both directions.
  assign from_ok = CW'(from_vertex_i) < CW'(n_i);
  assign to_ok   = CW'(to_vertex_i) < CW'(n_i);
  assign fa      = from_vertex_i[VW-1:0];
  assign tb      = to_vertex_i[VW-1:0];
  assign e_hi    = (fa > tb) ? fa : tb;
  assign e_lo    = (fa > tb) ? tb : fa;
  assign e_we_o    = in_accept && (req_type_i == dgsp_pkg::REQ_EDGE) && from_ok && to_ok;
  assign e_waddr_o = {e_hi, e_lo};
  assign e_wdata_o = WEIGHT_BITS'(weight_i);

  // Row of the picked vertex, read through the same triangle mapping.
  assign r_hi      = (best_q > cnt_q) ? best_q : cnt_q;
  assign r_lo      = (best_q > cnt_q) ? cnt_q : best_q;
  assign e_re_o    = relax_iss;
  assign e_raddr_o = {r_hi, r_lo};

  // Sequencer: init sweep, then scan and relax per round, then emit.
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    round_d   = round_q;
    scan_iss  = 1'b0;
    relax_iss = 1'b0;
    emit_iss  = 1'b0;
    init_we   = 1'b0;
    case (state_q)
      dgsp_pkg::ST_IDLE: begin
        if (in_accept && (req_type_i == dgsp_pkg::REQ_RUN)) begin
          state_d = dgsp_pkg::ST_INIT;
          cnt_d   = '0;
        end
      end
      dgsp_pkg::ST_INIT: begin
        init_we = 1'b1;
        if (cnt_q == n_m1) begin
          cnt_d   = '0;
          round_d = '0;
          state_d = (n_m1 == '0) ? dgsp_pkg::ST_EMIT : dgsp_pkg::ST_SCAN;
        end else begin
          cnt_d = cnt_q + VW'(1);
        end
      end
      dgsp_pkg::ST_SCAN: begin
        scan_iss = 1'b1;
        if (cnt_q == n_m1) begin
          cnt_d   = '0;
          state_d = dgsp_pkg::ST_SCAN_END;
        end else begin
          cnt_d = cnt_q + VW'(1);
        end
      end
      dgsp_pkg::ST_SCAN_END: begin
        state_d = dgsp_pkg::ST_RELAX;
      end
      dgsp_pkg::ST_RELAX: begin
        relax_iss = 1'b1;
        if (cnt_q == n_m1) begin
          cnt_d   = '0;
          state_d = dgsp_pkg::ST_RELAX_END;
        end else begin
          cnt_d = cnt_q + VW'(1);
        end
      end
      dgsp_pkg::ST_RELAX_END: begin
        if (round_q == n_m1 - VW'(1)) begin
          state_d = dgsp_pkg::ST_EMIT;
        end else begin
          round_d = round_q + VW'(1);
          state_d = dgsp_pkg::ST_SCAN;
        end
      end
      dgsp_pkg::ST_EMIT: begin
        if (!emit_v_q && (!out_valid_q || out_accept)) begin
          emit_iss = 1'b1;
          if (cnt_q == n_m1) begin
            cnt_d   = '0;
            state_d = dgsp_pkg::ST_IDLE;
          end else begin
            cnt_d = cnt_q + VW'(1);
          end
        end
      end
      default: begin
        state_d = dgsp_pkg::ST_IDLE;
      end
    endcase
  end

  // Minimum search compare on the word read in the previous cycle.
  assign take = !v_rdata_i.visited &&
                (!have_q || (v_rdata_i.reached &&
                             (!best_reached_q || (v_rdata_i.dist_val < best_dist_q))));

  // Relaxation of one neighbor, written back in the cycle its data returns.
  assign cand_full = SW'(best_dist_q) + SW'(e_rdata_i);
  assign cand      = (cand_full > SW'(dgsp_pkg::DIST_MAX)) ?
                     dgsp_pkg::DIST_MAX : cand_full[dgsp_pkg::DIST_BITS-1:0];

  always_comb begin
    wb_we    = 1'b0;
    wb_entry = v_rdata_i;
    if (relax_v_q) begin
      if (pipe_idx_q == best_q) begin
        wb_we            = 1'b1;
        wb_entry.visited = 1'b1;
      end else if (best_reached_q && (e_rdata_i != '0) && !v_rdata_i.visited &&
                   (!v_rdata_i.reached || (cand < v_rdata_i.dist_val))) begin
        wb_we             = 1'b1;
        wb_entry.visited  = 1'b0;
        wb_entry.reached  = 1'b1;
        wb_entry.dist_val = cand;
      end
    end
  end

  // Vertex memory port: init sweep and write-back never overlap.
  assign v_re_o    = scan_iss || relax_iss || emit_iss;
  assign v_raddr_o = cnt_q;
  assign v_we_o    = init_we || wb_we;
  assign v_waddr_o = init_we ? cnt_q : pipe_idx_q;
  always_comb begin
    if (init_we) begin
      v_wdata_o.visited  = 1'b0;
      v_wdata_o.reached  = (cnt_q == '0);
      v_wdata_o.dist_val = '0;
    end else begin
      v_wdata_o = wb_entry;
    end
  end

  // State and read pipeline flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dgsp_pkg::ST_IDLE;
      cnt_q     <= '0;
      round_q   <= '0;
      scan_v_q  <= 1'b0;
      relax_v_q <= 1'b0;
      emit_v_q  <= 1'b0;
      have_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      round_q   <= round_d;
      scan_v_q  <= scan_iss;
      relax_v_q <= relax_iss;
      emit_v_q  <= emit_iss;
      if ((state_q != dgsp_pkg::ST_SCAN) && (state_d == dgsp_pkg::ST_SCAN)) begin
        have_q <= 1'b0;
      end else if (scan_v_q && take) begin
        have_q <= 1'b1;
      end
    end
  end

  // Payload side of the pipeline and the best candidate.
  always_ff @(posedge clk_i) begin
    pipe_idx_q <= cnt_q;
    if (scan_v_q && take) begin
      best_q         <= pipe_idx_q;
      best_reached_q <= v_rdata_i.reached;
      best_dist_q    <= v_rdata_i.dist_val;
    end
  end

  // Output register; a read is issued only when it will be free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_v_q) begin
      out_valid_q <= 1'b1;
    end else if (out_accept) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_v_q) begin
      out_vertex_q <= dgsp_pkg::VID_BITS'(pipe_idx_q);
      out_dist_q   <= v_rdata_i.reached ? v_rdata_i.dist_val : '0;
      out_reach_q  <= v_rdata_i.reached;
      out_last_q   <= (pipe_idx_q == n_m1);
    end
  end

  assign out_valid_o = out_valid_q;
  assign vertex_o    = out_vertex_q;
  assign distance_o  = out_dist_q;
  assign reachable_o = out_reach_q;
  assign last_o      = out_last_q;

  // Returning emit data never lands on an occupied output register.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_v_q |-> !out_valid_q)
    else $error("emit data arrived while the output register was full");

  // Write-back and the next read never target the same vertex.
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_we_o && v_re_o) |-> (v_waddr_o != v_raddr_o))
    else $error("vertex memory read and write at the same address");

  // Relax data only returns while the relax phase is still open.
  a_relax_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    relax_v_q |-> ((state_q == dgsp_pkg::ST_RELAX) || (state_q == dgsp_pkg::ST_RELAX_END)))
    else $error("relax write-back outside the relax phase");

  // The final result of a run carries the highest active vertex.
  a_last_vertex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> (out_vertex_q == dgsp_pkg::VID_BITS'(n_m1)))
    else $error("last flag on a vertex other than the final one");

endmodule

[rtl/dense_graph_shortest_paths_unit.sv]
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i / in_stall_o req_type_i, from_vertex_i, to_vertex_i, weight_i
// out       output     out_valid_o/out_stall_i vertex_o, distance_o, reachable_o, last_o
// cfg       input      cfg_valid_i/cfg_ready_o cfg_data_i (vertex_count)
//
// After reset the weight memory is cleared, one entry per cycle, all 4**clog2(MAX_VERTICES)
// entries (4096 by default); no request is accepted on the in channel meanwhile.
// An edge transaction is one write into the lower triangle of the matrix.
// A run does an init sweep, then n-1 rounds (each a scan of the vertex memory and a
// relax pass over one matrix row), then emits one result per vertex, one at a time.
// The single read port of the vertex memory paces the scan, relax and emit phases;
// output stalls only stretch the emit phase.
module dense_graph_shortest_paths_unit #(
  parameter int unsigned MAX_VERTICES = dgsp_pkg::DEF_MAX_VERTICES,
  parameter int unsigned WEIGHT_BITS  = dgsp_pkg::DEF_WEIGHT_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dgsp_pkg::CFG_BITS-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           req_type_i,
  input  logic [dgsp_pkg::VID_BITS-1:0]  from_vertex_i,
  input  logic [dgsp_pkg::VID_BITS-1:0]  to_vertex_i,
  input  logic [dgsp_pkg::WIN_BITS-1:0]  weight_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [dgsp_pkg::VID_BITS-1:0]  vertex_o,
  output logic [dgsp_pkg::DIST_BITS-1:0] distance_o,
  output logic                           reachable_o,
  output logic                           last_o
);

  localparam int unsigned VW = $clog2(MAX_VERTICES);
  localparam int unsigned NW = $clog2(MAX_VERTICES + 1);

  logic [dgsp_pkg::CFG_BITS-1:0] cfg_q;
  logic [NW-1:0]                 n_eff;
  logic                          clear_busy;
  logic                          e_we, e_re;
  logic [2*VW-1:0]               e_waddr, e_raddr;
  logic [WEIGHT_BITS-1:0]        e_wdata, e_rdata;
  logic                          v_we, v_re;
  logic [VW-1:0]                 v_waddr, v_raddr;
  dgsp_pkg::vtx_entry_t          v_wdata, v_rdata;

  // Vertex count register.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= dgsp_pkg::CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cfg_q <= cfg_data_i;
    end
  end

  // Clamp the count into 1 to MAX_VERTICES.
  always_comb begin
    if (cfg_q == '0) begin
      n_eff = NW'(1);
    end else if (cfg_q > dgsp_pkg::CFG_BITS'(MAX_VERTICES)) begin
      n_eff = NW'(MAX_VERTICES);
    end else begin
      n_eff = NW'(cfg_q);
    end
  end

  dgsp_edge_mem #(
    .ADDR_BITS   (2 * VW),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_edge_mem (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .we_i         (e_we),
    .waddr_i      (e_waddr),
    .wdata_i      (e_wdata),
    .re_i         (e_re),
    .raddr_i      (e_raddr),
    .rdata_o      (e_rdata),
    .clear_busy_o (clear_busy)
  );

  dgsp_vtx_mem #(
    .ADDR_BITS (VW)
  ) u_vtx_mem (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (v_waddr),
    .wdata_i (v_wdata),
    .re_i    (v_re),
    .raddr_i (v_raddr),
    .rdata_o (v_rdata)
  );

  dgsp_ctrl #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS),
    .VW           (VW),
    .NW           (NW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .n_i           (n_eff),
    .clear_busy_i  (clear_busy),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .from_vertex_i (from_vertex_i),
    .to_vertex_i   (to_vertex_i),
    .weight_i      (weight_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .vertex_o      (vertex_o),
    .distance_o    (distance_o),
    .reachable_o   (reachable_o),
    .last_o        (last_o),
    .e_we_o        (e_we),
    .e_waddr_o     (e_waddr),
    .e_wdata_o     (e_wdata),
    .e_re_o        (e_re),
    .e_raddr_o     (e_raddr),
    .e_rdata_i     (e_rdata),
    .v_we_o        (v_we),
    .v_waddr_o     (v_waddr),
    .v_wdata_o     (v_wdata),
    .v_re_o        (v_re),
    .v_raddr_o     (v_raddr),
    .v_rdata_i     (v_rdata)
  );

endmodule

[dv/distance_checker.sv]
module distance_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [dgsp_pkg::CFG_BITS-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic                           req_type_i,
  input  logic [dgsp_pkg::VID_BITS-1:0]  from_vertex_i,
  input  logic [dgsp_pkg::VID_BITS-1:0]  to_vertex_i,
  input  logic [dgsp_pkg::WIN_BITS-1:0]  weight_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [dgsp_pkg::VID_BITS-1:0]  vertex_i,
  input  logic [dgsp_pkg::DIST_BITS-1:0] distance_i,
  input  logic                           reachable_i,
  input  logic                           last_i,
  output int unsigned                    pending_o,
  output int unsigned                    fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NV = dgsp_pkg::DEF_MAX_VERTICES;

  // One reported vertex of a search.
  typedef struct packed {
    logic [dgsp_pkg::VID_BITS-1:0]  vertex;
    logic [dgsp_pkg::DIST_BITS-1:0] distance;
    logic                           reachable;
    logic                           last;
  } dist_report_t;

  // Shadow copy of the adjacency matrix and the vertex count register.
  logic [dgsp_pkg::WIN_BITS-1:0] weights [NV][NV];
  logic [dgsp_pkg::CFG_BITS-1:0] vertex_count;
  dist_report_t                  expected_distances[$];
  int unsigned                   failures = 0;

  assign fail_count_o = failures;

  // Runs the search over the first n vertices and queues one report per vertex.
  function automatic void predict_distances(input int unsigned n);
    logic [dgsp_pkg::DIST_BITS-1:0] path_len [NV];
    logic                           reached [NV];
    logic                           visited [NV];
    logic [dgsp_pkg::DIST_BITS:0]   cand;
    int unsigned                    u;
    bit                             have;
    dist_report_t                   rep;
    for (int j = 0; j < NV; j++) begin
      path_len[j] = '0;
      reached[j]  = 1'b0;
      visited[j]  = 1'b0;
    end
    reached[0] = 1'b1;
    for (int unsigned r = 0; r + 1 < n; r++) begin
      // Lowest-index unvisited vertex with the smallest distance; unreached ones rank last.
      have = 1'b0;
      u = 0;
      for (int unsigned i = 0; i < n; i++) begin
        if (visited[i]) continue;
        if (!have) begin
          u = i;
          have = 1'b1;
        end else if (reached[i] && (!reached[u] || path_len[i] < path_len[u])) begin
          u = i;
        end
      end
      visited[u] = 1'b1;
      // An unreached vertex relaxes nothing.
      if (!reached[u]) continue;
      for (int unsigned j = 0; j < n; j++) begin
        if (weights[u][j] == '0 || visited[j]) continue;
        cand = {1'b0, path_len[u]} + weights[u][j];
        if (cand > {1'b0, dgsp_pkg::DIST_MAX}) cand = {1'b0, dgsp_pkg::DIST_MAX};
        if (!reached[j] || cand[dgsp_pkg::DIST_BITS-1:0] < path_len[j]) begin
          path_len[j] = cand[dgsp_pkg::DIST_BITS-1:0];
          reached[j]  = 1'b1;
        end
      end
    end
    for (int unsigned j = 0; j < n; j++) begin
      rep.vertex    = j[dgsp_pkg::VID_BITS-1:0];
      rep.distance  = reached[j] ? path_len[j] : '0;
      rep.reachable = reached[j];
      rep.last      = (j + 1 == n);
      expected_distances.push_back(rep);
    end
  endfunction

  // Watch all three channels; compare results first, then apply new transactions.
  always @(posedge clk_i) begin : watch
    int unsigned  n;
    dist_report_t want;
    if (!rst_ni) begin
      for (int a = 0; a < NV; a++) begin
        for (int b = 0; b < NV; b++) begin
          weights[a][b] = '0;
        end
      end
      vertex_count = dgsp_pkg::CFG_RESET;
      expected_distances.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_distances.size() == 0) begin
          $error("vertex: unexpected result for vertex %0d, nothing expected", vertex_i);
          failures++;
        end else begin
          want = expected_distances.pop_front();
          if (vertex_i !== want.vertex) begin
            $error("vertex: expected %0d, actual %0d", want.vertex, vertex_i);
            failures++;
          end
          if (distance_i !== want.distance) begin
            $error("distance: expected %0d, actual %0d", want.distance, distance_i);
            failures++;
          end
          if (reachable_i !== want.reachable) begin
            $error("reachable: expected %0d, actual %0d", want.reachable, reachable_i);
            failures++;
          end
          if (last_i !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, last_i);
            failures++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) vertex_count = cfg_data_i;
      if (in_valid_i && !in_stall_i) begin
        // A count of 0 acts as 1, anything above the matrix size as the matrix size.
        if (vertex_count == 0) n = 1;
        else if (vertex_count > NV) n = NV;
        else n = vertex_count;
        if (req_type_i == dgsp_pkg::REQ_EDGE) begin
          // Edges with an endpoint outside the active vertices are dropped.
          if (from_vertex_i < n && to_vertex_i < n) begin
            weights[from_vertex_i][to_vertex_i] = weight_i;
            weights[to_vertex_i][from_vertex_i] = weight_i;
          end
        end else begin
          predict_distances(n);
        end
      end
    end
    pending_o <= expected_distances.size();
  end

endmodule

[dv/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [dgsp_pkg::CFG_BITS-1:0] cfg_t;
  typedef logic [dgsp_pkg::VID_BITS-1:0] vid_t;
  typedef logic [dgsp_pkg::WIN_BITS-1:0] wgt_t;

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           cfg_valid_i   = 1'b0;
  logic                           cfg_ready_o;
  cfg_t                           cfg_data_i    = '0;
  logic                           in_valid_i    = 1'b0;
  logic                           in_stall_o;
  logic                           req_type_i    = dgsp_pkg::REQ_EDGE;
  vid_t                           from_vertex_i = '0;
  vid_t                           to_vertex_i   = '0;
  wgt_t                           weight_i      = '0;
  logic                           out_valid_o;
  logic                           out_stall_i   = 1'b0;
  vid_t                           vertex_o;
  logic [dgsp_pkg::DIST_BITS-1:0] distance_o;
  logic                           reachable_o;
  logic                           last_o;

  int unsigned pending;
  int unsigned fail_count;
  bit          steady_feed  = 1'b0;
  bit          steady_drain = 1'b0;
  int unsigned drain_left   = 0;

  // Clock with an 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  dense_graph_shortest_paths_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .from_vertex_i(from_vertex_i),
    .to_vertex_i  (to_vertex_i),
    .weight_i     (weight_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .vertex_o     (vertex_o),
    .distance_o   (distance_o),
    .reachable_o  (reachable_o),
    .last_o       (last_o)
  );

  distance_checker paths_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .req_type_i   (req_type_i),
    .from_vertex_i(from_vertex_i),
    .to_vertex_i  (to_vertex_i),
    .weight_i     (weight_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .vertex_i     (vertex_o),
    .distance_i   (distance_o),
    .reachable_i  (reachable_o),
    .last_i       (last_o),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // Result side: after each transaction, stall for a random number of valid cycles.
  always @(posedge clk_i) begin : drain
    int unsigned draw;
    if (out_valid_o && !out_stall_i) begin
      draw = steady_drain ? 0 : $urandom_range(0, 18);
      drain_left  <= draw;
      out_stall_i <= (draw != 0);
    end else if (out_valid_o && drain_left > 1) begin
      drain_left <= drain_left - 1;
    end else if (out_valid_o) begin
      drain_left  <= 0;
      out_stall_i <= 1'b0;
    end
  end

  // Offers one request after a random gap and holds it until it is taken.
  task automatic send_request(input logic kind, input vid_t a, input vid_t b, input wgt_t w);
    int unsigned gap;
    gap = steady_feed ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= kind;
    from_vertex_i <= a;
    to_vertex_i   <= b;
    weight_i      <= w;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_edge(input vid_t a, input vid_t b, input wgt_t w);
    send_request(dgsp_pkg::REQ_EDGE, a, b, w);
  endtask

  // The endpoint and weight fields of a run are don't-care, so they are random.
  task automatic start_search();
    send_request(dgsp_pkg::REQ_RUN, vid_t'($urandom_range(0, 63)),
                 vid_t'($urandom_range(0, 63)), wgt_t'($urandom));
  endtask

  // Drains every outstanding result, then lets a trailing edge write finish.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_vertex_count(input cfg_t v);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Stimulus: directed corner cases, a long heavy chain, then random graphs.
  initial begin : stimulus
    int unsigned counted;
    int unsigned big_phases;
    int unsigned n;
    int unsigned sel;
    bit          noise;
    cfg_t        vc;
    vid_t        a;
    vid_t        b;
    wgt_t        w;
    counted    = 0;
    big_phases = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // A count of zero behaves as a single vertex.
    write_vertex_count(7'd0);
    start_search();
    // Single vertex with a self loop on the source.
    write_vertex_count(7'd1);
    send_edge(6'd0, 6'd0, 16'hFFFF);
    start_search();
    // An oversized count acts as the full matrix; mostly unreachable vertices.
    write_vertex_count(7'd127);
    send_edge(6'd0, 6'd63, 16'hFFFF);
    send_edge(6'd63, 6'd62, 16'd1);
    send_edge(6'd5, 6'd5, 16'd7);
    send_edge(6'd0, 6'd1, 16'd0);
    start_search();
    // Four vertices: equal-distance ties, out-of-range endpoints, edge removal.
    write_vertex_count(7'd4);
    send_edge(6'd0, 6'd1, 16'd3);
    send_edge(6'd1, 6'd2, 16'd3);
    send_edge(6'd0, 6'd2, 16'd6);
    send_edge(6'd4, 6'd1, 16'd9);
    send_edge(6'd1, 6'd63, 16'd2);
    start_search();
    send_edge(6'd1, 6'd2, 16'd0);
    start_search();

    // A chain of heavy edges across all vertices drives distances toward the top.
    write_vertex_count(7'd64);
    send_edge(6'd0, 6'd63, 16'd0);
    for (int i = 0; i < 63; i++) begin
      send_edge(i[dgsp_pkg::VID_BITS-1:0], i[dgsp_pkg::VID_BITS-1:0] + 6'd1,
                wgt_t'($urandom_range(60000, 65535)));
    end
    start_search();
    counted = 65;

    // Random phases: one vertex count each, with one or two graph updates and runs.
    while (counted < 130) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0: vc = 7'd0;
        1: vc = 7'd1;
        2: vc = cfg_t'($urandom_range(65, 127));
        3: vc = 7'd64;
        default: vc = cfg_t'($urandom_range(2, 12));
      endcase
      // Full-size runs are slow, so only a couple are allowed.
      if (sel == 2 || sel == 3) begin
        if (big_phases >= 2) vc = cfg_t'($urandom_range(2, 12));
        else big_phases++;
      end
      write_vertex_count(vc);
      steady_feed  = ($urandom_range(0, 3) == 0);
      steady_drain <= ($urandom_range(0, 3) == 0);
      if (vc == 0) n = 1;
      else if (vc > 64) n = 64;
      else n = vc;
      repeat ($urandom_range(1, 2)) begin
        repeat ($urandom_range(2, 8)) begin
          noise = ($urandom_range(0, 5) == 0);
          a = vid_t'(noise ? $urandom_range(0, 63) : $urandom_range(0, n - 1));
          b = vid_t'(noise ? $urandom_range(0, 63) : $urandom_range(0, n - 1));
          // Small weights make ties common; zero removes edges.
          case ($urandom_range(0, 7))
            0: w = '0;
            1: w = '1;
            2, 3: w = wgt_t'($urandom_range(1, 3));
            default: w = wgt_t'($urandom);
          endcase
          send_edge(a, b, w);
          if (a < n && b < n) counted++;
        end
        start_search();
        counted++;
      end
    end

    settle();
    repeat (64) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
